// File: rtl/complex_arith_unit_defines.svh
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// implication in the same cycle
`define CAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("complex_arith_unit: implication check failed");

// consequence a fixed number of cycles later
`define CAU_ASSERT_DLY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error("complex_arith_unit: latency check failed");

`endif

// File: rtl/cau_pkg.sv
// types, constants and helpers of the complex arithmetic unit
package cau_pkg;

	localparam int DW = 32;          // width of one part
	localparam int FB = 16;          // fraction bits
	localparam int PW = 2 * DW;      // full product width
	localparam int SW = PW + 1;      // sum of two products
	localparam int NW = PW + FB;     // scaled divide numerator magnitude
	localparam int RW = PW + 1;      // divider remainder, needs FB <= DW + 1
	localparam int LAT = DW + 6;     // accept edge to result strobe

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic signed [DW-1:0] a_re;
		logic signed [DW-1:0] a_im;
		logic signed [DW-1:0] b_re;
		logic signed [DW-1:0] b_im;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] res_re;
		logic signed [DW-1:0] res_im;
		logic                 overflow;
		logic                 div_zero;
	} rsp_t;

	// control riding beside the divider lanes
	typedef struct packed {
		logic is_div;
		logic dz;
		logic neg_re;
		logic neg_im;
		rsp_t pass;
	} div_ctl_t;

	typedef struct packed {
		logic                 ovf;
		logic signed [DW-1:0] v;
	} sat_t;

	function automatic sat_t sat_sum(input logic signed [SW-1:0] x);
		sat_t r;
		r.ovf = !((&x[SW-1:DW-1]) || !(|x[SW-1:DW-1]));
		if (r.ovf) begin
			r.v = x[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			r.v = x[DW-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/cau_div_pipe.sv
// two-lane pipelined restoring divider with quotient saturation
module cau_div_pipe import cau_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  div_ctl_t        ctl,
	input  logic [NW-1:0]   num_re,
	input  logic [NW-1:0]   num_im,
	input  logic [PW-1:0]   den,
	output logic            vld_out,
	output rsp_t            rsp_out
);

	logic            vld_sn [0:DW];
	div_ctl_t        ctl_sn [0:DW];
	logic [PW-1:0]   den_sn [0:DW];
	logic [RW-1:0]   rem_sn [0:DW][0:1];
	logic [DW-1:0]   lo_sn  [0:DW][0:1];
	logic            big_sn [0:DW][0:1];
	logic [NW-1:0]   num_in [0:1];

	logic            vld_out_s;
	rsp_t            rsp_out_s;

	assign num_in[0] = num_re;
	assign num_in[1] = num_im;

	// entry stage: quotient range check, split numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn[0] <= 1'b0;
		end else begin
			vld_sn[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_sn[0] <= ctl;
		den_sn[0] <= den;
		for (int l = 0; l < 2; l++) begin
			big_sn[0][l] <= RW'(num_in[l][NW-1:DW]) >= RW'(den);
			rem_sn[0][l] <= RW'(num_in[l][NW-1:DW]);
			lo_sn[0][l]  <= num_in[l][DW-1:0];
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= DW; k++) begin : g_step
		logic [RW-1:0] t   [0:1];
		logic          ge  [0:1];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				t[l]  = {rem_sn[k-1][l][RW-2:0], lo_sn[k-1][l][DW-1]};
				ge[l] = t[l] >= RW'(den_sn[k-1]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else begin
				vld_sn[k] <= vld_sn[k-1];
			end
		end

		always_ff @(posedge clk) begin
			ctl_sn[k] <= ctl_sn[k-1];
			den_sn[k] <= den_sn[k-1];
			for (int l = 0; l < 2; l++) begin
				big_sn[k][l] <= big_sn[k-1][l];
				rem_sn[k][l] <= ge[l] ? t[l] - RW'(den_sn[k-1]) : t[l];
				lo_sn[k][l]  <= {lo_sn[k-1][l][DW-2:0], ge[l]};
			end
		end
	end

	// sign and saturate the quotients
	logic                 neg [0:1];
	logic                 ovl [0:1];
	logic signed [DW-1:0] qv  [0:1];
	rsp_t                 rsp_d;

	always_comb begin
		neg[0] = ctl_sn[DW].neg_re;
		neg[1] = ctl_sn[DW].neg_im;
		for (int l = 0; l < 2; l++) begin
			if (neg[l]) begin
				ovl[l] = big_sn[DW][l] ||
					(lo_sn[DW][l][DW-1] && (|lo_sn[DW][l][DW-2:0]));
			end else begin
				ovl[l] = big_sn[DW][l] || lo_sn[DW][l][DW-1];
			end
			if (ovl[l]) begin
				qv[l] = neg[l] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
			end else begin
				qv[l] = neg[l] ? -lo_sn[DW][l] : lo_sn[DW][l];
			end
		end
		if (!ctl_sn[DW].is_div) begin
			rsp_d = ctl_sn[DW].pass;
		end else if (ctl_sn[DW].dz) begin
			rsp_d = '0;
			rsp_d.div_zero = 1'b1;
		end else begin
			rsp_d.res_re   = qv[0];
			rsp_d.res_im   = qv[1];
			rsp_d.overflow = ovl[0] || ovl[1];
			rsp_d.div_zero = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s <= 1'b0;
		end else begin
			vld_out_s <= vld_sn[DW];
		end
	end

	always_ff @(posedge clk) begin
		rsp_out_s <= rsp_d;
	end

	assign vld_out = vld_out_s;
	assign rsp_out = rsp_out_s;

endmodule

// File: rtl/complex_arith_unit.sv
// top level of the complex arithmetic unit
//
// complex add, subtract, multiply and divide on signed Q16.16 parts
// request channel: drive req and raise start; a word is taken at each rising
//   edge where start is high and busy is low; busy never rises, so a new word
//   may enter every cycle
// result channel: done pulses for one cycle with the word on rsp; the
//   receiver cannot hold results off, results leave in request order
// path: every operation takes the same path from the accept edge to the result,
//   including the 32 one-bit stages of the restoring divider
// throughput: one word per cycle for all operations
// stages: input register, six 32x32 multipliers, product sums, scaling and
//   signs, divider range check, 32 divider steps, saturation
// overflow marks a saturated part, div_zero a divide by a zero divisor, which
//   returns zero parts with overflow low
// reset: clears every valid bit in flight; words in the pipe are dropped and
//   nothing is strobed until new words arrive
`include "complex_arith_unit_defines.svh"

module complex_arith_unit import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  req_t  req,
	output logic  done,
	output rsp_t  rsp
);

	// stage 1: capture the request word
	logic v_s1;
	req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	// stage 2: all cross and square products, add/sub at one extra bit
	logic                 v_s2;
	cmd_t                 cmd_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_bb_r_s2, p_bb_i_s2;
	logic signed [DW:0]   as_re_s2, as_im_s2;
	logic signed [DW:0]   ea_re, ea_im, eb_re, eb_im;

	assign ea_re = {req_s1.a_re[DW-1], req_s1.a_re};
	assign ea_im = {req_s1.a_im[DW-1], req_s1.a_im};
	assign eb_re = {req_s1.b_re[DW-1], req_s1.b_re};
	assign eb_im = {req_s1.b_im[DW-1], req_s1.b_im};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2    <= req_s1.cmd;
		p_rr_s2   <= req_s1.a_re * req_s1.b_re;
		p_ii_s2   <= req_s1.a_im * req_s1.b_im;
		p_ri_s2   <= req_s1.a_re * req_s1.b_im;
		p_ir_s2   <= req_s1.a_im * req_s1.b_re;
		p_bb_r_s2 <= req_s1.b_re * req_s1.b_re;
		p_bb_i_s2 <= req_s1.b_im * req_s1.b_im;
		as_re_s2  <= (req_s1.cmd == CMD_SUB) ? ea_re - eb_re : ea_re + eb_re;
		as_im_s2  <= (req_s1.cmd == CMD_SUB) ? ea_im - eb_im : ea_im + eb_im;
	end

	// stage 3: product sums at full width
	logic                 v_s3;
	cmd_t                 cmd_s3;
	logic signed [SW-1:0] mre_s3, mim_s3, dre_s3, dim_s3;
	logic [PW-1:0]        den_s3;
	logic signed [DW:0]   as_re_s3, as_im_s3;
	logic signed [SW-1:0] x_rr, x_ii, x_ri, x_ir;

	assign x_rr = {p_rr_s2[PW-1], p_rr_s2};
	assign x_ii = {p_ii_s2[PW-1], p_ii_s2};
	assign x_ri = {p_ri_s2[PW-1], p_ri_s2};
	assign x_ir = {p_ir_s2[PW-1], p_ir_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3   <= cmd_s2;
		mre_s3   <= x_rr - x_ii;
		mim_s3   <= x_ri + x_ir;
		dre_s3   <= x_rr + x_ii;
		dim_s3   <= x_ir - x_ri;
		// squares are never negative, their sum is at most 2^(PW-1) and fits unsigned
		den_s3   <= p_bb_r_s2 + p_bb_i_s2;
		as_re_s3 <= as_re_s2;
		as_im_s3 <= as_im_s2;
	end

	// stage 4: finish add/sub/mul, magnitudes and signs for divide
	logic                 v_s4;
	div_ctl_t             ctl_s4;
	logic [NW-1:0]        nre_s4, nim_s4;
	logic [PW-1:0]        den_s4;

	logic signed [SW-1:0] sh_re, sh_im, wa_re, wa_im, mag_re, mag_im;
	sat_t                 s_re, s_im;
	div_ctl_t             ctl_d;

	always_comb begin
		sh_re = mre_s3 >>> FB;
		sh_im = mim_s3 >>> FB;
		wa_re = {{(SW-DW-1){as_re_s3[DW]}}, as_re_s3};
		wa_im = {{(SW-DW-1){as_im_s3[DW]}}, as_im_s3};
		if (cmd_s3 == CMD_MUL) begin
			s_re = sat_sum(sh_re);
			s_im = sat_sum(sh_im);
		end else begin
			s_re = sat_sum(wa_re);
			s_im = sat_sum(wa_im);
		end
		mag_re = dre_s3[SW-1] ? -dre_s3 : dre_s3;
		mag_im = dim_s3[SW-1] ? -dim_s3 : dim_s3;
		ctl_d.is_div        = (cmd_s3 == CMD_DIV);
		ctl_d.dz            = (den_s3 == '0);
		ctl_d.neg_re        = dre_s3[SW-1];
		ctl_d.neg_im        = dim_s3[SW-1];
		ctl_d.pass.res_re   = s_re.v;
		ctl_d.pass.res_im   = s_im.v;
		ctl_d.pass.overflow = s_re.ovf || s_im.ovf;
		ctl_d.pass.div_zero = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s4 <= ctl_d;
		nre_s4 <= {mag_re[PW-1:0], {FB{1'b0}}};
		nim_s4 <= {mag_im[PW-1:0], {FB{1'b0}}};
		den_s4 <= den_s3;
	end

	// divider and final saturation; other operations ride along unchanged
	cau_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (v_s4),
		.ctl     (ctl_s4),
		.num_re  (nre_s4),
		.num_im  (nim_s4),
		.den     (den_s4),
		.vld_out (done),
		.rsp_out (rsp)
	);

	// the pipe never stalls
	assign busy = 1'b0;

	`CAU_ASSERT_DLY(a_latency, start && !busy, LAT, done)
	`CAU_ASSERT_IMP(a_flags_excl, done, !(rsp.overflow && rsp.div_zero))
	`CAU_ASSERT_IMP(a_dz_zero, done && rsp.div_zero, rsp.res_re == '0 && rsp.res_im == '0)
	`CAU_ASSERT_DLY(a_dz_source, v_s4 && ctl_s4.is_div && ctl_s4.dz, DW + 2, rsp.div_zero)

endmodule
